/* rtl/core/crt_pkg.sv */
// shared types and constants of the csv record tokenizer
`timescale 1ns / 1ps

package crt_pkg;

    // character codes
    localparam logic [15:0] CH_QUOTE = 16'h0022;
    localparam logic [15:0] CH_COMMA = 16'h002C;
    localparam logic [15:0] CH_CR    = 16'h000D;
    localparam logic [15:0] CH_LF    = 16'h000A;

    // result kinds
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_FIELD  = 2'd1;
    localparam logic [1:0] KIND_RECORD = 2'd2;

    // one classified item: first result, plus a flag for a trailing end of record
    typedef struct packed {
        logic        two;
        logic [1:0]  kind;
        logic [15:0] ch;
    } t_entry;

    // tokenizer flags, exported for checking
    typedef struct packed {
        logic in_quotes;
        logic quote_pending;
        logic cr_pending;
        logic field_begun;
        logic record_open;
    } t_flags;

    // queue status between front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* rtl/core/csv_record_tokenizer_unit.sv */
// Top level of the csv record tokenizer: front end, item queue, back end.
// An accepted item is written into the queue and then loaded from its head into the output register.
// One character per cycle while the queue is not full and items give at most one result each;
// an item with two results occupies the single output register for both of its results, one after the other.
// Reset: synchronous active-low i_rst_n clears the tokenizer flags, queue and output valid.
`timescale 1ns / 1ps

module csv_record_tokenizer_unit import crt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_char_code,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_field_char,
    output logic        o_last_of_item
);

    logic      push;
    logic      pop;
    t_entry    push_entry;
    t_entry    head;
    t_q_status q_status;
    t_flags    flags;

    // front end
    crt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .i_q_full      (q_status.full),
        .o_ready       (o_ready),
        .o_push        (push),
        .o_entry       (push_entry),
        .o_flags       (flags)
    );

    // item queue
    crt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // back end
    crt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_q_empty      (q_status.empty),
        .o_pop          (pop),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_field_char   (o_field_char),
        .o_last_of_item (o_last_of_item)
    );

    // all flags clear after the final character of a text
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_end_of_text) |=> (flags == '0))
        else $error("flags not cleared after end of text");

    // a pending quote only exists inside a quoted field
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flags.quote_pending |-> flags.in_quotes)
        else $error("quote pending outside quotes");

    // marks carry a zero character
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_CHAR) |-> (o_field_char == '0))
        else $error("mark item with nonzero character");

    // queue never both full and empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");

endmodule

/* rtl/core/crt_front.sv */
// front end: accepts characters, tracks quote/cr state, classifies each item
`timescale 1ns / 1ps

module crt_front import crt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_char_code,
    input  logic        i_end_of_text,
    input  logic        i_q_full,
    output logic        o_ready,
    output logic        o_push,
    output t_entry      o_entry,
    output t_flags      o_flags
);

    t_flags r_flags, n_flags;
    logic   accept;
    logic   done;
    logic   have0;
    t_entry entry;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // classification of the current character and next flag values
    always_comb begin
        n_flags    = r_flags;
        done       = 1'b0;
        have0      = 1'b0;
        entry.two  = 1'b0;
        entry.kind = KIND_CHAR;
        entry.ch   = i_char_code;

        // resolve one-character lookahead
        if (r_flags.cr_pending) begin
            n_flags.cr_pending = 1'b0;
            if (i_char_code == CH_LF) begin
                done = 1'b1;
            end
        end else if (r_flags.quote_pending) begin
            n_flags.quote_pending = 1'b0;
            if (i_char_code == CH_QUOTE) begin
                have0    = 1'b1;
                entry.ch = CH_QUOTE;
                done     = 1'b1;
            end else begin
                n_flags.in_quotes = 1'b0;
            end
        end

        // main character handling
        if (!done) begin
            if (n_flags.in_quotes) begin
                if (i_char_code == CH_QUOTE) begin
                    if (i_end_of_text) begin
                        n_flags.in_quotes = 1'b0;
                    end else begin
                        n_flags.quote_pending = 1'b1;
                    end
                end else begin
                    have0 = 1'b1;
                end
            end else if (i_char_code == CH_QUOTE) begin
                n_flags.in_quotes   = 1'b1;
                n_flags.field_begun = 1'b1;
            end else if (i_char_code == CH_COMMA) begin
                have0               = 1'b1;
                entry.kind          = KIND_FIELD;
                entry.ch            = '0;
                n_flags.record_open = 1'b1;
                n_flags.field_begun = 1'b1;
            end else if (i_char_code == CH_CR || i_char_code == CH_LF) begin
                have0               = 1'b1;
                entry.kind          = KIND_RECORD;
                entry.ch            = '0;
                n_flags.field_begun = 1'b0;
                n_flags.record_open = 1'b0;
                n_flags.cr_pending  = (i_char_code == CH_CR);
            end else begin
                have0               = 1'b1;
                n_flags.field_begun = 1'b1;
            end
        end

        // end of text: flush an open field or record, then start over
        if (i_end_of_text) begin
            if (n_flags.field_begun || n_flags.record_open) begin
                if (have0) begin
                    entry.two = 1'b1;
                end else begin
                    have0      = 1'b1;
                    entry.kind = KIND_RECORD;
                    entry.ch   = '0;
                end
            end
            n_flags = '0;
        end
    end

    assign o_push  = accept && have0;
    assign o_entry = entry;
    assign o_flags = r_flags;

    // flag register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (accept) begin
            r_flags <= n_flags;
        end
    end

endmodule

/* rtl/core/crt_queue.sv */
// two-entry queue of classified items between front and back
`timescale 1ns / 1ps

module crt_queue import crt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_entry    o_head,
    output t_q_status o_status
);

    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       do_push;
    logic       do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* rtl/core/crt_back.sv */
// back end: expands queued items into results and holds the output register
`timescale 1ns / 1ps

module crt_back import crt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_head,
    input  logic        i_q_empty,
    output logic        o_pop,
    input  logic        i_ready,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [15:0] o_field_char,
    output logic        o_last_of_item
);

    logic        r_valid, n_valid;
    logic        r_second, n_second;
    logic [1:0]  r_kind, n_kind;
    logic [15:0] r_ch, n_ch;
    logic        r_last, n_last;
    logic        load;

    assign load = !i_q_empty && (!r_valid || i_ready);

    // result selection: first result of the item, then its trailing end of record
    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_kind   = r_kind;
        n_ch     = r_ch;
        n_last   = r_last;
        o_pop    = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            if (!r_second) begin
                n_kind = i_head.kind;
                n_ch   = i_head.ch;
                n_last = !i_head.two;
                if (i_head.two) begin
                    n_second = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_kind   = KIND_RECORD;
                n_ch     = '0;
                n_last   = 1'b1;
                n_second = 1'b0;
                o_pop    = 1'b1;
            end
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_ch   <= n_ch;
        r_last <= n_last;
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_field_char   = r_ch;
    assign o_last_of_item = r_last;

endmodule
